// ----- sv/trd_pkg.sv -----
// shared types and constants of the tls record deframer
package trd_pkg;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HDR_OK  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_HDR_BAD = 2'd2
   } kind_type;

   localparam logic [7:0] CT_CCS          = 8'h14;
   localparam logic [7:0] CT_LOW          = 8'h14;
   localparam logic [7:0] CT_HIGH         = 8'h18;
   localparam logic [7:0] MAJOR_TLS       = 8'd3;
   localparam logic [7:0] MAX_MINOR_RESET = 8'd4;
   localparam logic [2:0] HDR_LAST_IDX    = 3'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  content_type;
      logic [7:0]  minor_version;
      logic [15:0] record_length;
      logic [7:0]  payload_byte;
      logic [15:0] payload_offset;
      logic        last_of_record;
      logic        cipher_change_seen;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- sv/trd_ifs.sv -----
// channel interfaces: byte input, result output and configuration write
interface trd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       segment_start;

   modport source (output valid, output stream_byte, output segment_start, input ready);
   modport sink   (input valid, input stream_byte, input segment_start, output ready);
endinterface

interface trd_rsp_if;
   import trd_pkg::*;
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [7:0]  content_type;
   logic [7:0]  minor_version;
   logic [15:0] record_length;
   logic [7:0]  payload_byte;
   logic [15:0] payload_offset;
   logic        last_of_record;
   logic        cipher_change_seen;

   modport source (output valid, output kind, output content_type, output minor_version,
                   output record_length, output payload_byte, output payload_offset,
                   output last_of_record, output cipher_change_seen, input ready);
   modport sink   (input valid, input kind, input content_type, input minor_version,
                   input record_length, input payload_byte, input payload_offset,
                   input last_of_record, input cipher_change_seen, output ready);
endinterface

interface trd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] max_minor_version;

   modport source (output valid, output max_minor_version, input ready);
   modport sink   (input valid, input max_minor_version, output ready);
endinterface

// ----- sv/tls_record_deframer.sv -----
// tls record deframer top level: front end, command queue, back end
// a result is queued when its stream beat is accepted, then registered in the back end for rsp
// throughput: one stream beat per cycle unless the queue is full (combinational framing update)
// the two-entry queue takes two more result commands while rsp is stalled before input stops
// reset (synchronous): gathering a fresh header, queue and output empty, max minor version 4
module tls_record_deframer (
   input logic      clock,
   input logic      reset,
   trd_req_if.sink  req_ch,
   trd_rsp_if.source rsp_ch,
   trd_csr_if.sink  csr_ch
);
   import trd_pkg::*;

   logic      push;
   logic      pop;
   cmd_type   push_cmd;
   cmd_type   head_cmd;
   qstat_type q_stat;

   trd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .csr_ch   (csr_ch),
      .q_stat   (q_stat),
      .push     (push),
      .push_cmd (push_cmd)
   );

   trd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   trd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ----- sv/trd_front.sv -----
// front end: takes stream beats, tracks record framing and queues result commands
module trd_front (
   input  logic              clock,
   input  logic              reset,
   trd_req_if.sink           req_ch,
   trd_csr_if.sink           csr_ch,
   input  trd_pkg::qstat_type q_stat,
   output logic              push,
   output trd_pkg::cmd_type  push_cmd
);
   import trd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hcount_ff, hcount_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  major_ff, major_in;
   logic [7:0]  minor_ff, minor_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] pcount_ff, pcount_in;
   logic        ccs_ff, ccs_in;
   logic [7:0]  max_minor_ff, max_minor_in;

   logic        accept;
   logic [2:0]  idx;
   logic [16:0] next_off;
   logic        last;
   logic        hdr_ok;
   logic        take;

   assign req_ch.ready = !q_stat.full;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && !q_stat.full;

   always_comb begin
      max_minor_in = csr_ch.valid ? csr_ch.max_minor_version : max_minor_ff;
   end

   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      type_in   = type_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      length_in = length_ff;
      pcount_in = pcount_ff;
      ccs_in    = ccs_ff;
      push      = 1'b0;
      idx       = (phase_ff == PH_HEADER) ? hcount_ff : 3'd0;
      next_off  = {1'b0, pcount_ff} + 17'd1;
      last      = next_off >= {1'b0, length_ff};
      hdr_ok    = 1'b0;
      take      = (phase_ff == PH_HEADER) || req_ch.segment_start;

      push_cmd.kind               = KIND_PAYLOAD;
      push_cmd.content_type       = type_ff;
      push_cmd.minor_version      = minor_ff;
      push_cmd.record_length      = length_ff;
      push_cmd.payload_byte       = req_ch.stream_byte;
      push_cmd.payload_offset     = pcount_ff;
      push_cmd.last_of_record     = last;
      push_cmd.cipher_change_seen = ccs_ff;

      if (accept) begin
         if (phase_ff == PH_PAYLOAD) begin
            push      = 1'b1;
            pcount_in = next_off[15:0];
            if (last) begin
               phase_in  = PH_HEADER;
               hcount_in = 3'd0;
            end
         end else if (take) begin
            phase_in = PH_HEADER;
            case (idx)
               3'd0:    type_in   = req_ch.stream_byte;
               3'd1:    major_in  = req_ch.stream_byte;
               3'd2:    minor_in  = req_ch.stream_byte;
               3'd3:    length_in = {req_ch.stream_byte, 8'd0};
               default: length_in = {length_ff[15:8], req_ch.stream_byte};
            endcase
            hcount_in = idx + 3'd1;
            if (idx == HDR_LAST_IDX) begin
               // header complete: check it and report
               hcount_in = 3'd0;
               push      = 1'b1;
               hdr_ok    = (type_ff >= CT_LOW) && (type_ff <= CT_HIGH) &&
                           (major_ff == MAJOR_TLS) && (minor_ff <= max_minor_ff);
               push_cmd.record_length  = length_in;
               push_cmd.payload_offset = 16'd0;
               if (hdr_ok) begin
                  if (type_ff == CT_CCS) ccs_in = 1'b1;
                  pcount_in               = 16'd0;
                  push_cmd.kind           = KIND_HDR_OK;
                  push_cmd.last_of_record = (length_in == 16'd0);
                  phase_in = (length_in == 16'd0) ? PH_HEADER : PH_PAYLOAD;
               end else begin
                  push_cmd.kind           = KIND_HDR_BAD;
                  push_cmd.last_of_record = 1'b0;
                  phase_in                = PH_DISCARD;
               end
               push_cmd.cipher_change_seen = ccs_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hcount_ff    <= 3'd0;
         ccs_ff       <= 1'b0;
         max_minor_ff <= MAX_MINOR_RESET;
      end else begin
         phase_ff     <= phase_in;
         hcount_ff    <= hcount_in;
         ccs_ff       <= ccs_in;
         max_minor_ff <= max_minor_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      major_ff  <= major_in;
      minor_ff  <= minor_in;
      length_ff <= length_in;
      pcount_ff <= pcount_in;
   end

endmodule

// ----- sv/trd_queue.sv -----
// short command queue between front and back end
module trd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  trd_pkg::cmd_type   push_cmd,
   input  logic               pop,
   output trd_pkg::cmd_type   head_cmd,
   output trd_pkg::qstat_type q_stat
);
   import trd_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0]   rptr_ff, rptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign q_stat.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_cmd     = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wptr_ff] <= push_cmd;
   end

endmodule

// ----- sv/trd_back.sv -----
// back end: drains queued commands into the registered result channel
module trd_back (
   input  logic               clock,
   input  logic               reset,
   input  trd_pkg::cmd_type   head_cmd,
   input  trd_pkg::qstat_type q_stat,
   output logic               pop,
   trd_rsp_if.source          rsp_ch
);
   import trd_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type out_ff, out_in;
   logic    is_payload;

   assign pop        = !q_stat.empty && (!valid_ff || rsp_ch.ready);
   assign valid_in   = pop || (valid_ff && !rsp_ch.ready);
   assign is_payload = (head_cmd.kind == KIND_PAYLOAD);

   always_comb begin
      out_in = out_ff;
      if (pop) begin
         out_in = head_cmd;
         // byte and offset only mean something on payload beats
         out_in.payload_byte   = is_payload ? head_cmd.payload_byte : 8'd0;
         out_in.payload_offset = is_payload ? head_cmd.payload_offset : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_ch.valid              = valid_ff;
   assign rsp_ch.kind               = out_ff.kind;
   assign rsp_ch.content_type       = out_ff.content_type;
   assign rsp_ch.minor_version      = out_ff.minor_version;
   assign rsp_ch.record_length      = out_ff.record_length;
   assign rsp_ch.payload_byte       = out_ff.payload_byte;
   assign rsp_ch.payload_offset     = out_ff.payload_offset;
   assign rsp_ch.last_of_record     = out_ff.last_of_record;
   assign rsp_ch.cipher_change_seen = out_ff.cipher_change_seen;

endmodule

// ----- tb/sv/tb_tls_record_deframer.sv -----
// testbench of the tls record deframer: directed table, then random record streams
module tb_tls_record_deframer;
   import trd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR_BYTES   = 5;
   localparam int DRAIN_WAIT  = 6;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_BEATS = 180;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       seg;
      logic       pinned;
      kind_type   kind;
      logic       fin;
      logic       ccs;
   } stim_row_type;

   // rows with pinned set carry the kind, last flag and ccs flag they must give
   localparam stim_row_type DIRECTED [27] = '{
      '{8'h16, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h03, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h03, 1'b1, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},  // mark mid header is ignored
      '{8'h00, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, KIND_HDR_OK,  1'b1, 1'b0},  // zero length record
      '{8'h14, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h03, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h04, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},  // minor right at the limit
      '{8'h00, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h01, 1'b0, 1'b1, KIND_HDR_OK,  1'b0, 1'b1},
      '{8'hFF, 1'b1, 1'b1, KIND_PAYLOAD, 1'b1, 1'b1},
      '{8'h13, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},  // type just below range
      '{8'h03, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h01, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h02, 1'b0, 1'b1, KIND_HDR_BAD, 1'b0, 1'b1},
      '{8'hAA, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},  // dropped while discarding
      '{8'h19, 1'b1, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},  // resync, type just above range
      '{8'h03, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b1, KIND_HDR_BAD, 1'b0, 1'b1},
      '{8'h18, 1'b1, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h02, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},  // wrong major version
      '{8'h00, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, KIND_HDR_OK,  1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, KIND_HDR_BAD, 1'b0, 1'b1}
   };

   logic clock;
   logic reset;

   trd_req_if req_if();
   trd_rsp_if rsp_if();
   trd_csr_if csr_if();

   tls_record_deframer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // pinned expectation travels with the beat on the bus
   logic     pin_on;
   kind_type pin_kind;
   logic     pin_last;
   logic     pin_ccs;

   bit idle_on;
   int stall_left;
   int beats_sent;
   int mismatches;
   int cycle_count;

   // predictor state and its copy of the register
   phase_type   rx_phase;
   logic [2:0]  hdr_count;
   logic [7:0]  hdr_type;
   logic [7:0]  hdr_major;
   logic [7:0]  hdr_minor;
   logic [15:0] hdr_length;
   logic [15:0] pay_count;
   logic        ccs_seen;
   logic [7:0]  minor_limit;

   cmd_type pending_results[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic stim_row_type plain(input logic [7:0] b, input logic seg);
      return '{b, seg, 1'b0, KIND_HDR_OK, 1'b0, 1'b0};
   endfunction

   function automatic logic seg_noise();
      return ($urandom_range(0, 9) == 0);
   endfunction

   // one accepted stream byte; queues the result it gives, if any
   function automatic bit deframe_beat(input logic [7:0] b, input logic seg);
      cmd_type r;
      int      off;
      bit      has_result;
      bit      ok;
      r = '0;
      has_result = 1'b0;
      if (rx_phase == PH_PAYLOAD) begin
         off = pay_count;
         r.kind = KIND_PAYLOAD;
         r.payload_byte = b;
         r.payload_offset = 16'(off);
         r.last_of_record = (off + 1 >= hdr_length);
         pay_count = 16'(off + 1);
         if (r.last_of_record) begin
            rx_phase = PH_HEADER;
            hdr_count = '0;
         end
         has_result = 1'b1;
      end else begin
         if (rx_phase != PH_HEADER && seg) begin
            rx_phase = PH_HEADER;
            hdr_count = '0;
         end
         if (rx_phase == PH_HEADER) begin
            case (hdr_count)
               3'd0: hdr_type = b;
               3'd1: hdr_major = b;
               3'd2: hdr_minor = b;
               3'd3: hdr_length = {b, 8'h00};
               default: hdr_length[7:0] = b;
            endcase
            hdr_count = hdr_count + 3'd1;
            if (hdr_count == HDR_BYTES) begin
               hdr_count = '0;
               ok = hdr_type >= CT_LOW && hdr_type <= CT_HIGH && hdr_major == MAJOR_TLS
                    && hdr_minor <= minor_limit;
               if (!ok) begin
                  rx_phase = PH_DISCARD;
                  r.kind = KIND_HDR_BAD;
               end else begin
                  if (hdr_type == CT_CCS) ccs_seen = 1'b1;
                  pay_count = '0;
                  r.kind = KIND_HDR_OK;
                  r.last_of_record = (hdr_length == 16'd0);
                  rx_phase = r.last_of_record ? PH_HEADER : PH_PAYLOAD;
               end
               has_result = 1'b1;
            end
         end
      end
      if (has_result) begin
         r.content_type = hdr_type;
         r.minor_version = hdr_minor;
         r.record_length = hdr_length;
         r.cipher_change_seen = ccs_seen;
         pending_results.push_back(r);
      end
      return has_result;
   endfunction

   function automatic void check_field(input string fname, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns %s: expected %0h, got %0h", $time, fname, want, got);
         mismatches++;
      end
   endfunction

   // predictor, register copy and result checking
   always @(posedge clock) begin
      cmd_type want;
      if (reset) begin
         rx_phase = PH_HEADER;
         hdr_count = '0;
         hdr_type = '0;
         hdr_major = '0;
         hdr_minor = '0;
         hdr_length = '0;
         pay_count = '0;
         ccs_seen = 1'b0;
         minor_limit = MAX_MINOR_RESET;
         pending_results.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) minor_limit = csr_if.max_minor_version;
         if (req_if.valid && req_if.ready) begin
            if (deframe_beat(req_if.stream_byte, req_if.segment_start) && pin_on) begin
               want = pending_results.pop_back();
               want.kind = pin_kind;
               want.last_of_record = pin_last;
               want.cipher_change_seen = pin_ccs;
               pending_results.push_back(want);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t ns result beat with nothing expected, kind %0d", $time,
                        rsp_if.kind);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_if.kind));
               check_field("content_type", 16'(want.content_type), 16'(rsp_if.content_type));
               check_field("minor_version", 16'(want.minor_version),
                           16'(rsp_if.minor_version));
               check_field("record_length", want.record_length, rsp_if.record_length);
               check_field("payload_byte", 16'(want.payload_byte), 16'(rsp_if.payload_byte));
               check_field("payload_offset", want.payload_offset, rsp_if.payload_offset);
               check_field("last_of_record", 16'(want.last_of_record),
                           16'(rsp_if.last_of_record));
               check_field("cipher_change_seen", 16'(want.cipher_change_seen),
                           16'(rsp_if.cipher_change_seen));
            end
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= gap_len();
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL tls_record_deframer");
         $finish;
      end
   end

   task automatic put_beat(input stim_row_type row);
      int gap;
      req_if.valid <= 1'b1;
      req_if.stream_byte <= row.byte_val;
      req_if.segment_start <= row.seg;
      pin_on <= row.pinned;
      pin_kind <= row.kind;
      pin_last <= row.fin;
      pin_ccs <= row.ccs;
      do @(posedge clock); while (!req_if.ready);
      beats_sent++;
      gap = idle_on ? gap_len() : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      // a byte that gives no result may still be in flight
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_minor_limit(input logic [7:0] v);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.max_minor_version <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // mostly well-formed records, some bad headers and loose noise bytes
   task automatic run_records(input logic [7:0] limit, input int quota);
      int          target;
      int          sel;
      int          n;
      logic [7:0]  ctype;
      logic [7:0]  major;
      logic [7:0]  minor;
      logic [15:0] len;
      target = beats_sent + quota;
      while (beats_sent < target) begin
         idle_on = ($urandom_range(0, 5) != 0);
         sel = $urandom_range(0, 99);
         if (sel < 75) begin
            ctype = 8'($urandom_range(CT_LOW, CT_HIGH));
            minor = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, limit))
                                                 : 8'($urandom);
            n = $urandom_range(0, 19);
            len = (n < 14) ? 16'($urandom_range(0, 12)) : 16'($urandom_range(13, 300));
            put_beat(plain(ctype, 1'($urandom_range(0, 1))));
            put_beat(plain(MAJOR_TLS, seg_noise()));
            put_beat(plain(minor, seg_noise()));
            put_beat(plain(len[15:8], seg_noise()));
            put_beat(plain(len[7:0], seg_noise()));
            n = (minor <= limit) ? int'(len) : $urandom_range(0, 3);
            // now and then a record cut short
            if (n > 0 && $urandom_range(0, 19) == 0) n = $urandom_range(0, n - 1);
            repeat (n) put_beat(plain(8'($urandom), seg_noise()));
         end else if (sel < 90) begin
            ctype = 8'($urandom_range(CT_LOW, CT_HIGH));
            major = MAJOR_TLS;
            minor = 8'($urandom_range(0, limit));
            case ($urandom_range(0, 2))
               0: ctype = $urandom_range(0, 1) ? 8'($urandom_range(0, CT_LOW - 1))
                                               : 8'($urandom_range(CT_HIGH + 1, 255));
               1: begin
                  major = 8'($urandom);
                  if (major == MAJOR_TLS) major = ~major;
               end
               default: begin
                  if (limit != 8'hFF) minor = 8'($urandom_range(limit + 1, 255));
                  else ctype = 8'($urandom_range(0, CT_LOW - 1));
               end
            endcase
            len = 16'($urandom);
            put_beat(plain(ctype, 1'b1));
            put_beat(plain(major, 1'b0));
            put_beat(plain(minor, 1'b0));
            put_beat(plain(len[15:8], 1'b0));
            put_beat(plain(len[7:0], 1'b0));
            repeat ($urandom_range(0, 4)) put_beat(plain(8'($urandom), 1'b0));
         end else begin
            repeat ($urandom_range(1, 8)) begin
               put_beat(plain(8'($urandom), 1'($urandom_range(0, 1))));
            end
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.stream_byte = '0;
      req_if.segment_start = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.max_minor_version = '0;
      rsp_if.ready = 1'b0;
      pin_on = 1'b0;
      pin_kind = KIND_HDR_OK;
      pin_last = 1'b0;
      pin_ccs = 1'b0;
      idle_on = 1'b0;
      stall_left = 0;
      beats_sent = 0;
      mismatches = 0;
      cycle_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      foreach (DIRECTED[i]) put_beat(DIRECTED[i]);

      // the directed part ends discarding, so a marked header starts cleanly here
      write_minor_limit(8'hFF);
      idle_on = 1'b0;
      put_beat(plain(8'h17, 1'b1));
      put_beat(plain(MAJOR_TLS, 1'b0));
      put_beat(plain(8'hFF, 1'b0));
      put_beat(plain(8'h01, 1'b0));
      put_beat(plain(8'h00, 1'b0));
      repeat (256) put_beat(plain(8'($urandom), seg_noise()));
      run_records(8'hFF, PHASE_BEATS);

      write_minor_limit(8'h00);
      run_records(8'h00, PHASE_BEATS);
      write_minor_limit(8'h03);
      run_records(8'h03, PHASE_BEATS);
      begin
         logic [7:0] lim;
         lim = 8'($urandom_range(5, 254));
         write_minor_limit(lim);
         run_records(lim, PHASE_BEATS);
      end
      write_minor_limit(MAX_MINOR_RESET);
      run_records(MAX_MINOR_RESET, PHASE_BEATS);

      wait_drained();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS tls_record_deframer");
      end else begin
         $display("FAIL tls_record_deframer");
      end
      $finish;
   end

endmodule
